[sv/rcsfd_pkg.sv]
// rcsfd_pkg: shared types and constants for the rc serial frame decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package rcsfd_pkg;

   localparam int FRAME_BYTES_DEF  = 16;
   localparam int NUM_CHANNELS_DEF = 7;

   localparam int OUT_CHANNELS = 7;
   localparam int VAL_W        = 10;
   localparam int CMD_W        = 8;
   localparam int SEL_W        = 3;
   localparam int CH_NUM_W     = 4;
   localparam int HI_W         = 2;
   localparam int LO_W         = 8;
   localparam int CSR_IDX_W    = 2;

   localparam int CMD_MAX = 127;
   localparam int CMD_MIN = -127;

   localparam logic [7:0] CH_FIELD_MASK = 8'b0011_1100;
   localparam logic [7:0] HI_FIELD_MASK = 8'h03;
   localparam int         CH_FIELD_LSB  = 2;

   // item kinds on the request channel
   localparam logic REQ_BYTE    = 1'b0;
   localparam logic REQ_TIMEOUT = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINEAR_CHANNEL  = 2'd0,
      CSR_ANGULAR_CHANNEL = 2'd1,
      CSR_LINEAR_BIAS     = 2'd2,
      CSR_ANGULAR_BIAS    = 2'd3
   } csr_index_type;

   localparam logic [SEL_W-1:0] LINEAR_CHANNEL_RST  = 3'd0;
   localparam logic [SEL_W-1:0] ANGULAR_CHANNEL_RST = 3'd1;
   localparam logic [VAL_W-1:0] BIAS_RST            = 10'd512;

   typedef struct packed {
      logic [SEL_W-1:0] linear_channel;
      logic [SEL_W-1:0] angular_channel;
      logic [VAL_W-1:0] linear_bias;
      logic [VAL_W-1:0] angular_bias;
   } cfg_type;

   typedef struct packed {
      logic signed [CMD_W-1:0]              linear_cmd;
      logic signed [CMD_W-1:0]              angular_cmd;
      logic [OUT_CHANNELS-1:0][VAL_W-1:0]   chan;
   } result_type;

endpackage

`default_nettype wire

[sv/rc_serial_frame_decoder.sv]
// rc_serial_frame_decoder: one byte or gap timeout accepted per cycle while req_stall is low.
// a completing byte writes its result into the result queue at its accept edge, and it leaves on rsp in order.
// a two-entry result queue decouples the sides; req_stall rises only when both
// entries hold results and the rsp side is stalled.
// synchronous reset clears position, channel values and queue, and loads
// register defaults (linear 0, angular 1, both biases 512).
`default_nettype none

module rc_serial_frame_decoder
   import rcsfd_pkg::*;
#(
   parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [7:0]            req_data_byte,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [CMD_W-1:0]    rsp_linear_cmd,
   output logic signed [CMD_W-1:0]    rsp_angular_cmd,
   output logic [VAL_W-1:0]           rsp_chan_0,
   output logic [VAL_W-1:0]           rsp_chan_1,
   output logic [VAL_W-1:0]           rsp_chan_2,
   output logic [VAL_W-1:0]           rsp_chan_3,
   output logic [VAL_W-1:0]           rsp_chan_4,
   output logic [VAL_W-1:0]           rsp_chan_5,
   output logic [VAL_W-1:0]           rsp_chan_6,

   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [VAL_W-1:0]      csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        req_accept;
   logic        dec_push;
   result_type  dec_result;
   result_type  rsp_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LINEAR_CHANNEL:  cfg_in.linear_channel  = csr_write_data[SEL_W-1:0];
            CSR_ANGULAR_CHANNEL: cfg_in.angular_channel = csr_write_data[SEL_W-1:0];
            CSR_LINEAR_BIAS:     cfg_in.linear_bias     = csr_write_data;
            CSR_ANGULAR_BIAS:    cfg_in.angular_bias    = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_channel  <= LINEAR_CHANNEL_RST;
         cfg_ff.angular_channel <= ANGULAR_CHANNEL_RST;
         cfg_ff.linear_bias     <= BIAS_RST;
         cfg_ff.angular_bias    <= BIAS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_accept = req_valid && !req_stall;

   rcsfd_decode #(
      .FRAME_BYTES  (FRAME_BYTES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (req_accept),
      .in_type    (req_type),
      .in_byte    (req_data_byte),
      .cfg        (cfg_ff),
      .out_push   (dec_push),
      .out_result (dec_result)
   );

   rcsfd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_push),
      .push_data (dec_result),
      .full_hold (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_result)
   );

   assign rsp_linear_cmd  = rsp_result.linear_cmd;
   assign rsp_angular_cmd = rsp_result.angular_cmd;
   assign rsp_chan_0      = rsp_result.chan[0];
   assign rsp_chan_1      = rsp_result.chan[1];
   assign rsp_chan_2      = rsp_result.chan[2];
   assign rsp_chan_3      = rsp_result.chan[3];
   assign rsp_chan_4      = rsp_result.chan[4];
   assign rsp_chan_5      = rsp_result.chan[5];
   assign rsp_chan_6      = rsp_result.chan[6];

endmodule

`default_nettype wire

[sv/rcsfd_decode.sv]
// rcsfd_decode: frame position tracking, channel value store and command math
// depends on rcsfd_pkg
`default_nettype none

module rcsfd_decode
   import rcsfd_pkg::*;
#(
   parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_accept,
   input  wire logic             in_type,
   input  wire logic [7:0]       in_byte,
   input  wire cfg_type          cfg,
   output logic                  out_push,
   output result_type            out_result
);

   localparam int POS_W = $clog2(FRAME_BYTES + 1);
   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CH_NUM_W-1:0] NUM_CH = CH_NUM_W'(NUM_CHANNELS);

   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   logic [CH_W-1:0]  cur_ff, cur_in;
   logic [HI_W-1:0]  hi_ff, hi_in;
   logic [VAL_W-1:0] val_ff [NUM_CHANNELS];
   logic [VAL_W-1:0] val_in [NUM_CHANNELS];

   logic [CH_NUM_W-1:0] lead_ch;
   logic [HI_W-1:0]     lead_hi;
   logic [CH_NUM_W-1:0] lin_sel, ang_sel;
   logic [VAL_W-1:0]    lin_val, ang_val;
   logic [VAL_W-1:0]    chan_out [OUT_CHANNELS];

   function automatic logic signed [CMD_W-1:0] make_cmd(input logic [VAL_W-1:0] val,
                                                        input logic [VAL_W-1:0] bias);
      logic signed [VAL_W:0] diff;
      logic signed [VAL_W:0] rnd;
      logic signed [VAL_W:0] half;
      diff = $signed({1'b0, val}) - $signed({1'b0, bias});
      // add one to negatives before the shift so they truncate toward zero
      rnd  = diff + $signed({{VAL_W{1'b0}}, diff[VAL_W]});
      half = rnd >>> 1;
      if (half > CMD_MAX) begin
         make_cmd = CMD_W'(CMD_MAX);
      end else if (half < CMD_MIN) begin
         make_cmd = CMD_W'(CMD_MIN);
      end else begin
         make_cmd = half[CMD_W-1:0];
      end
   endfunction

   assign pos_inc = pos_ff + 1'b1;
   assign lead_ch = CH_NUM_W'((in_byte & CH_FIELD_MASK) >> CH_FIELD_LSB);
   assign lead_hi = HI_W'(in_byte & HI_FIELD_MASK);

   always_comb begin
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      hi_in    = hi_ff;
      val_in   = val_ff;
      out_push = 1'b0;
      if (in_accept) begin
         if (in_type == REQ_TIMEOUT) begin
            pos_in = '0;
         end else if (pos_inc > POS_W'(2) && pos_inc[0] && lead_ch >= NUM_CH) begin
            // bad channel number aborts the frame
            pos_in = '0;
         end else begin
            if (pos_inc > POS_W'(2)) begin
               if (pos_inc[0]) begin
                  cur_in                     = lead_ch[CH_W-1:0];
                  hi_in                      = lead_hi;
                  val_in[lead_ch[CH_W-1:0]]  = {lead_hi, {LO_W{1'b0}}};
               end else begin
                  // leading byte of this pair set the high bits, low bits were zero
                  val_in[cur_ff] = {hi_ff, in_byte};
               end
            end
            if (pos_inc == POS_W'(FRAME_BYTES)) begin
               pos_in   = '0;
               out_push = 1'b1;
            end else begin
               pos_in = pos_inc;
            end
         end
      end
   end

   assign lin_sel = CH_NUM_W'(cfg.linear_channel);
   assign ang_sel = CH_NUM_W'(cfg.angular_channel);
   assign lin_val = (lin_sel < NUM_CH) ? val_in[lin_sel[CH_W-1:0]] : '0;
   assign ang_val = (ang_sel < NUM_CH) ? val_in[ang_sel[CH_W-1:0]] : '0;

   for (genvar k = 0; k < OUT_CHANNELS; k++) begin : g_chan
      if (k < NUM_CHANNELS) begin : g_live
         assign chan_out[k] = val_in[k];
      end else begin : g_none
         assign chan_out[k] = '0;
      end
   end

   always_comb begin
      out_result.linear_cmd  = make_cmd(lin_val, cfg.linear_bias);
      out_result.angular_cmd = make_cmd(ang_val, cfg.angular_bias);
      for (int k = 0; k < OUT_CHANNELS; k++) begin
         out_result.chan[k] = chan_out[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cur_ff <= '0;
         hi_ff  <= '0;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            val_ff[k] <= '0;
         end
      end else begin
         pos_ff <= pos_in;
         cur_ff <= cur_in;
         hi_ff  <= hi_in;
         val_ff <= val_in;
      end
   end

endmodule

`default_nettype wire

[sv/rcsfd_out_queue.sv]
// rcsfd_out_queue: two-entry result queue between the decoder and the rsp channel
// depends on rcsfd_pkg
`default_nettype none

module rcsfd_out_queue
   import rcsfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire result_type  push_data,
   output logic             full_hold,
   output logic             out_valid,
   input  wire logic        out_stall,
   output result_type       out_data
);

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // full and nothing leaving this cycle: no room for a result next edge
   assign full_hold = (count_ff == 2'd2) && !pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire
